### sv/ibm_pkg.sv
// Package for the IDE bus-master DMA engine: payload types, result kinds, function codes.
// Used by ibm_front, ibm_queue, ibm_back and ide_bus_master_prd_dma. No dependencies.
`timescale 1ns / 1ps
package ibm_pkg;
  localparam int SECTOR_BYTES = 512;
  localparam int SEC_W = $clog2(SECTOR_BYTES + 1);
  localparam int OFF_W = $clog2(SECTOR_BYTES);

  localparam logic [2:0] FN_WRITE = 3'd0;
  localparam logic [2:0] FN_READ  = 3'd1;
  localparam logic [2:0] FN_DESC  = 3'd2;
  localparam logic [2:0] FN_SECT  = 3'd3;
  localparam logic [2:0] FN_IRQ   = 3'd4;

  localparam logic [2:0] K_READ  = 3'd0;
  localparam logic [2:0] K_DONE  = 3'd1;
  localparam logic [2:0] K_SEG   = 3'd2;
  localparam logic [2:0] K_FETCH = 3'd3;
  localparam logic [2:0] K_SECT  = 3'd4;
  localparam logic [2:0] K_INACT = 3'd5;
  localparam logic [2:0] K_SHORT = 3'd6;
  localparam logic [2:0] K_BUSY  = 3'd7;

  localparam logic [2:0] OFF_CMD  = 3'd0;
  localparam logic [2:0] OFF_STAT = 3'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic        channel;
    logic [2:0]  reg_offset;
    logic [7:0]  write_data;
    logic [31:0] desc_base_word;
    logic [31:0] desc_count_word;
    logic        to_memory;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        result_channel;
    logic [7:0]  read_data;
    logic [31:0] mem_address;
    logic [9:0]  byte_count;
    logic [8:0]  buf_offset;
    logic        seg_to_memory;
    logic        last;
  } out_item_t;

  // one beat of the item queue: up to three results decided by the front
  typedef struct packed {
    logic [2:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  r2;
  } job_t;

  function automatic out_item_t mk(input logic [2:0] k, input logic ch);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.result_channel = ch;
    return r;
  endfunction
endpackage

### sv/ibm_front.sv
// Front end: holds per-channel register state, decides the results of each item.
// Depends on ibm_pkg.
`timescale 1ns / 1ps
module ibm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ibm_pkg::in_item_t in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output ibm_pkg::job_t     job
);
  logic [7:0]  command_reg [2];
  logic [7:0]  status_reg [2];
  logic [31:0] table_pointer [2];
  logic [31:0] cur_ptr [2];
  logic [31:0] seg_addr [2];
  logic [15:0] seg_left [2];
  logic        eot [2];
  logic        awaiting [2];
  logic [ibm_pkg::SEC_W-1:0] sec_left [2];
  logic        sec_dir [2];

  logic [7:0]  cmd_n, stat_n;
  logic [31:0] tp_n, cp_n, sa_n;
  logic [15:0] sl_n;
  logic        eot_n, aw_n, sd_n;
  logic [ibm_pkg::SEC_W-1:0] sec_n;
  ibm_pkg::job_t job_n;
  logic        c;
  logic [15:0] take;
  logic        run;
  logic [1:0]  sh;

  assign in_ready = !job_valid || job_ready;
  assign c = in_data.channel;
  assign sh = in_data.reg_offset[1:0];

  // add one result to the job being built
  function automatic ibm_pkg::job_t push(input ibm_pkg::job_t j, input ibm_pkg::out_item_t r);
    ibm_pkg::job_t o;
    o = j;
    unique case (j.cnt)
      3'd0: o.r0 = r;
      3'd1: o.r1 = r;
      default: o.r2 = r;
    endcase
    o.cnt = j.cnt + 3'd1;
    return o;
  endfunction

  // per-item decision
  always_comb begin
    ibm_pkg::out_item_t r;
    cmd_n = command_reg[c]; stat_n = status_reg[c]; tp_n = table_pointer[c];
    cp_n = cur_ptr[c]; sa_n = seg_addr[c]; sl_n = seg_left[c]; eot_n = eot[c];
    aw_n = awaiting[c]; sec_n = sec_left[c]; sd_n = sec_dir[c];
    job_n = '0; run = 1'b0; take = '0; r = '0;
    unique case (in_data.func)
      ibm_pkg::FN_WRITE: begin
        if (in_data.reg_offset == ibm_pkg::OFF_CMD) begin
          if (in_data.write_data[0] && !command_reg[c][0]) begin
            cp_n = table_pointer[c]; aw_n = 1'b1; sec_n = '0; stat_n[0] = 1'b1;
            r = ibm_pkg::mk(ibm_pkg::K_FETCH, c);
            r.mem_address = table_pointer[c];
            job_n = push(job_n, r);
          end else begin
            if (!in_data.write_data[0] && command_reg[c][0]) begin
              stat_n[0] = 1'b0; aw_n = 1'b0; sec_n = '0;
            end
            job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_DONE, c));
          end
          cmd_n = in_data.write_data;
        end else begin
          if (in_data.reg_offset == ibm_pkg::OFF_STAT)
            stat_n = (in_data.write_data & 8'h60) | (status_reg[c] & ~in_data.write_data & 8'h06)
                     | (status_reg[c] & 8'h01);
          else if (in_data.reg_offset[2])
            unique case (sh)
              2'd0: tp_n[7:0] = in_data.write_data;
              2'd1: tp_n[15:8] = in_data.write_data;
              2'd2: tp_n[23:16] = in_data.write_data;
              default: tp_n[31:24] = in_data.write_data;
            endcase
          job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_DONE, c));
        end
      end
      ibm_pkg::FN_READ: begin
        r = ibm_pkg::mk(ibm_pkg::K_READ, c);
        r.read_data = 8'hff;
        if (in_data.reg_offset == ibm_pkg::OFF_CMD) r.read_data = command_reg[c];
        else if (in_data.reg_offset == ibm_pkg::OFF_STAT) r.read_data = status_reg[c];
        else if (in_data.reg_offset[2])
          unique case (sh)
            2'd0: r.read_data = table_pointer[c][7:0];
            2'd1: r.read_data = table_pointer[c][15:8];
            2'd2: r.read_data = table_pointer[c][23:16];
            default: r.read_data = table_pointer[c][31:24];
          endcase
        job_n = push(job_n, r);
      end
      ibm_pkg::FN_DESC: begin
        if (!awaiting[c]) job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_BUSY, c));
        else begin
          sa_n = {in_data.desc_base_word[31:1], 1'b0};
          sl_n = {in_data.desc_count_word[15:1], 1'b0};
          eot_n = in_data.desc_count_word[31];
          cp_n = cur_ptr[c] + 32'd8;
          aw_n = 1'b0;
          run = sec_left[c] != '0;
        end
      end
      ibm_pkg::FN_SECT: begin
        if (!status_reg[c][0]) job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_INACT, c));
        else if (sec_left[c] != '0) job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_BUSY, c));
        else begin
          sec_n = ibm_pkg::SEC_W'(ibm_pkg::SECTOR_BYTES);
          sd_n = in_data.to_memory;
          run = !awaiting[c];
        end
      end
      ibm_pkg::FN_IRQ: begin
        stat_n[2] = 1'b1;
        job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_DONE, c));
      end
      default: job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_BUSY, c));
    endcase
    // split the pending sector along the current descriptor
    if (run) begin
      if (sl_n < 16'(sec_n) && eot_n) begin
        job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_SHORT, c));
        stat_n[0] = 1'b0; sec_n = '0;
      end else begin
        take = (sl_n < 16'(sec_n)) ? sl_n : 16'(sec_n);
        if (take != '0) begin
          r = ibm_pkg::mk(ibm_pkg::K_SEG, c);
          r.mem_address = sa_n;
          r.byte_count = 10'(take);
          r.buf_offset = ibm_pkg::OFF_W'(ibm_pkg::SEC_W'(ibm_pkg::SECTOR_BYTES) - sec_n);
          r.seg_to_memory = sd_n;
          job_n = push(job_n, r);
        end
        sa_n = sa_n + 32'(take);
        sl_n = sl_n - take;
        sec_n = sec_n - ibm_pkg::SEC_W'(take);
        if (sl_n == '0) begin
          if (eot_n) stat_n[0] = 1'b0;
          else begin
            r = ibm_pkg::mk(ibm_pkg::K_FETCH, c);
            r.mem_address = cp_n;
            job_n = push(job_n, r);
            aw_n = 1'b1;
          end
        end
        if (sec_n == '0) job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_SECT, c));
      end
    end
    if (in_data.func == ibm_pkg::FN_DESC && awaiting[c] && job_n.cnt == 3'd0)
      job_n = push(job_n, ibm_pkg::mk(ibm_pkg::K_DONE, c));
    // mark the last result
    unique case (job_n.cnt)
      3'd1: job_n.r0.last = 1'b1;
      3'd2: job_n.r1.last = 1'b1;
      default: job_n.r2.last = 1'b1;
    endcase
  end

  // state and job register; an item with no results (sector waiting on a fetch) leaves no job
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        command_reg[i] <= '0; status_reg[i] <= '0; table_pointer[i] <= '0;
        cur_ptr[i] <= '0; seg_addr[i] <= '0; seg_left[i] <= '0; eot[i] <= 1'b0;
        awaiting[i] <= 1'b0; sec_left[i] <= '0; sec_dir[i] <= 1'b0;
      end
    end else begin
      if (in_valid && in_ready) begin
        job_valid <= job_n.cnt != 3'd0;
        job <= job_n;
        command_reg[c] <= cmd_n; status_reg[c] <= stat_n; table_pointer[c] <= tp_n;
        cur_ptr[c] <= cp_n; seg_addr[c] <= sa_n; seg_left[c] <= sl_n; eot[c] <= eot_n;
        awaiting[c] <= aw_n; sec_left[c] <= sec_n; sec_dir[c] <= sd_n;
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end
endmodule

### sv/ibm_queue.sv
// Two-entry queue of decided jobs between front and back.
// Depends on ibm_pkg.
`timescale 1ns / 1ps
module ibm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ibm_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ibm_pkg::job_t rd_data
);
  ibm_pkg::job_t mem [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign wr_ready = fill != 2'd2;
  assign rd_valid = fill != 2'd0;
  assign rd_data = mem[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_data; wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      fill <= fill + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

### sv/ibm_back.sv
// Back end: issues the results of each job one beat at a time.
// Depends on ibm_pkg.
`timescale 1ns / 1ps
module ibm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  ibm_pkg::job_t      job,
  output logic               out_valid,
  input  logic               out_ready,
  output ibm_pkg::out_item_t out_data
);
  logic [1:0] idx;
  logic       fin;

  assign out_valid = job_valid;
  assign fin = (3'(idx) + 3'd1) >= job.cnt;
  assign job_ready = out_valid && out_ready && fin;

  // pick the result for this beat
  always_comb begin
    unique case (idx)
      2'd0: out_data = job.r0;
      2'd1: out_data = job.r1;
      default: out_data = job.r2;
    endcase
  end

  // result index within the job
  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else if (out_valid && out_ready) idx <= fin ? 2'd0 : idx + 2'd1;
  end
endmodule

### sv/ide_bus_master_prd_dma.sv
// IDE bus-master DMA engine with descriptor tables, two channels.
// An item's first result comes out through the front register and then the queue.
// The back issues one result per cycle while out_ready is high; an item's results (1..3) go out one after another.
// The front takes one item per cycle while the queue has room.
// Reset (rst, synchronous): all channel registers zero, queue empty.
`timescale 1ns / 1ps
module ide_bus_master_prd_dma (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ibm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ibm_pkg::out_item_t out_data
);
  logic          f_valid, f_ready, q_valid, q_ready;
  ibm_pkg::job_t f_job, q_job;

  ibm_front u_front (.clk, .rst, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job));
  ibm_queue u_queue (.clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job));
  ibm_back u_back (.clk, .rst, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid, .out_ready, .out_data);

  // every queued job has at least one result
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_job.cnt != 3'd0 && q_job.cnt <= 3'd3)) else $error("bad job count");
  // a sector complete result always closes its item
  a_sect: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == ibm_pkg::K_SECT |-> out_data.last) else $error("sect not last");
  // a job leaves the queue only on its last beat
  a_last: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> out_data.last) else $error("job popped early");
endmodule
